@@ hw/rtl/suffix_automaton_build_and_match_defines.svh @@
// assertion macros for the suffix automaton block
`ifndef SUFFIX_AUTOMATON_BUILD_AND_MATCH_DEFINES_SVH
`define SUFFIX_AUTOMATON_BUILD_AND_MATCH_DEFINES_SVH
`ifndef SYNTH
`define SAB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SAB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SAB_ASSERT_NOW(lbl, ante, cons)
`define SAB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/sab_pkg.sv @@
// constants and types shared by the suffix automaton block
`default_nettype none
package sab_pkg;
  localparam int MAX_TEXT = 1024;
  localparam int ALPHABET = 256;
  localparam int NODE_CAP = 2 * MAX_TEXT;
  localparam int NODE_W   = $clog2(NODE_CAP);
  localparam int SYM_W    = $clog2(ALPHABET);
  localparam int LEN_W    = $clog2(MAX_TEXT + 1);
  localparam int POS_W    = 10;
  localparam int EADDR_W  = NODE_W + SYM_W;
  localparam int EDGE_DEPTH = NODE_CAP * ALPHABET;

  localparam logic [1:0] ST_APPENDED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_ANSWER   = 2'd2;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [NODE_W-1:0] link;
    logic [LEN_W-1:0]  fep;
  } node_t;

  localparam int NODE_WORD_W = $bits(node_t);
endpackage
`default_nettype wire

@@ hw/rtl/suffix_automaton_build_and_match.sv @@
// suffix automaton: an append reads the last node, writes the new node, then walks suffix links one step at a time
// a clone copies the edge row of q (ALPHABET entries), then redirects matching edges along the suffix links
// query bytes follow edges from the matched node, the last one ends in the output register
// one item in flight; next item accepted while a result waits on the output
// after reset a clearing pass writes NODE_CAP*ALPHABET (524288) edge entries, one per cycle,
// with input stalled; async active-low reset clears the state, node and length counters, query state and output valid
`default_nettype none
`include "suffix_automaton_build_and_match_defines.svh"
module suffix_automaton_build_and_match (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic                      mode_i,
  input  wire logic [7:0]                symbol_i,
  input  wire logic                      pattern_end_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [1:0]                     status_o,
  output logic                           found_o,
  output logic [sab_pkg::POS_W-1:0]      position_o
);
  localparam int NW = sab_pkg::NODE_W;
  localparam int SW = sab_pkg::SYM_W;
  localparam int LW = sab_pkg::LEN_W;

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] A_RDLAST  = 4'd2;
  localparam logic [3:0] A_NEW     = 4'd3;
  localparam logic [3:0] A_WALK    = 4'd4;
  localparam logic [3:0] A_CHKQ    = 4'd5;
  localparam logic [3:0] A_COPY    = 4'd6;
  localparam logic [3:0] A_RDP     = 4'd7;
  localparam logic [3:0] A_REDIR   = 4'd8;
  localparam logic [3:0] A_FIXQ    = 4'd9;
  localparam logic [3:0] A_FIXCUR  = 4'd10;
  localparam logic [3:0] Q_EDGE    = 4'd11;
  localparam logic [3:0] Q_POS     = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  logic [3:0] state_q, state_d;
  logic [sab_pkg::EADDR_W-1:0] clr_q, clr_d;
  logic [NW:0] node_cnt_q, node_cnt_d;
  logic [NW-1:0] last_q, last_d, qnode_q, qnode_d;
  logic [LW-1:0] text_len_q, text_len_d, qlen_q, qlen_d;
  logic qfail_q, qfail_d;
  logic [SW-1:0] sym_q, sym_d;
  logic pend_q, pend_d;
  logic [NW-1:0] p_q, p_d, q_q, q_d, cl_q, cl_d, cur_q, cur_d;
  logic [LW-1:0] cur_len_q, cur_len_d, lenp_q, lenp_d;
  sab_pkg::node_t qword_q, qword_d;
  logic [SW:0] k_q, k_d;
  logic [1:0] res_st_q, res_st_d;
  logic res_found_q, res_found_d;
  logic [sab_pkg::POS_W-1:0] res_pos_q, res_pos_d;
  logic out_valid_q, out_valid_d;
  logic [1:0] status_q, status_d;
  logic found_q, found_d;
  logic [sab_pkg::POS_W-1:0] pos_q, pos_d;

  logic e_we;
  logic [sab_pkg::EADDR_W-1:0] e_waddr, e_raddr;
  logic [NW-1:0] e_wdata, e_rdata;
  logic n_we;
  logic [NW-1:0] n_waddr, n_raddr;
  sab_pkg::node_t n_wdata, n_raw, nd;
  logic n_root_q;

  logic accept;
  logic [SW-1:0] in_sym;
  logic [LW-1:0] pos_full;

  sab_ram #(.DEPTH(sab_pkg::EDGE_DEPTH), .WIDTH(NW)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  sab_ram #(.DEPTH(sab_pkg::NODE_CAP), .WIDTH(sab_pkg::NODE_WORD_W)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .raddr_i (n_raddr),
    .rdata_o (n_raw)
  );

  // root entry is never written and reads as zero
  assign nd = n_root_q ? '0 : n_raw;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign in_sym      = symbol_i[SW-1:0];
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign found_o     = found_q;
  assign position_o  = pos_q;
  assign pos_full    = nd.fep + LW'(1) - qlen_q;

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    node_cnt_d = node_cnt_q;
    last_d = last_q;
    qnode_d = qnode_q;
    text_len_d = text_len_q;
    qlen_d = qlen_q;
    qfail_d = qfail_q;
    sym_d = sym_q;
    pend_d = pend_q;
    p_d = p_q;
    q_d = q_q;
    cl_d = cl_q;
    cur_d = cur_q;
    cur_len_d = cur_len_q;
    lenp_d = lenp_q;
    qword_d = qword_q;
    k_d = k_q;
    res_st_d = res_st_q;
    res_found_d = res_found_q;
    res_pos_d = res_pos_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d = status_q;
    found_d = found_q;
    pos_d = pos_q;
    e_we = 1'b0;
    e_waddr = {p_q, sym_q};
    e_wdata = cur_q;
    e_raddr = {p_q, sym_q};
    n_we = 1'b0;
    n_waddr = cur_q;
    n_wdata = '{len: cur_len_q, link: cl_q, fep: cur_len_q - LW'(1)};
    n_raddr = p_q;

    unique case (state_q)
      S_CLR: begin
        e_we = 1'b1;
        e_waddr = clr_q;
        e_wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          sym_d = in_sym;
          pend_d = pattern_end_i;
          res_found_d = 1'b0;
          res_pos_d = '0;
          if (!mode_i) begin
            qnode_d = '0;
            qlen_d = '0;
            qfail_d = 1'b0;
            if (text_len_q >= LW'(sab_pkg::MAX_TEXT)) begin
              res_st_d = sab_pkg::ST_FULL;
              state_d = S_DONE;
            end else begin
              text_len_d = text_len_q + 1'b1;
              res_st_d = sab_pkg::ST_APPENDED;
              n_raddr = last_q;
              state_d = A_RDLAST;
            end
          end else begin
            if (qlen_q != '1) begin
              qlen_d = qlen_q + 1'b1;
            end
            res_st_d = sab_pkg::ST_ANSWER;
            if (!qfail_q) begin
              e_raddr = {qnode_q, in_sym};
              state_d = Q_EDGE;
            end else if (pattern_end_i) begin
              qnode_d = '0;
              qlen_d = '0;
              qfail_d = 1'b0;
              state_d = S_DONE;
            end
          end
        end
      end
      A_RDLAST: begin
        n_raddr = last_q;
        state_d = A_NEW;
      end
      A_NEW: begin
        cur_d = node_cnt_q[NW-1:0];
        cur_len_d = nd.len + 1'b1;
        n_we = 1'b1;
        n_waddr = node_cnt_q[NW-1:0];
        n_wdata = '{len: nd.len + 1'b1, link: '0, fep: nd.len};
        node_cnt_d = node_cnt_q + 1'b1;
        last_d = node_cnt_q[NW-1:0];
        p_d = last_q;
        e_raddr = {last_q, sym_q};
        n_raddr = last_q;
        state_d = A_WALK;
      end
      A_WALK: begin
        if (e_rdata == '0) begin
          e_we = 1'b1;
          if (p_q == '0) begin
            state_d = S_DONE;
          end else begin
            p_d = nd.link;
            e_raddr = {nd.link, sym_q};
            n_raddr = nd.link;
          end
        end else begin
          q_d = e_rdata;
          lenp_d = nd.len;
          n_raddr = e_rdata;
          state_d = A_CHKQ;
        end
      end
      A_CHKQ: begin
        n_we = 1'b1;
        if (nd.len == lenp_q + 1'b1) begin
          n_wdata = '{len: cur_len_q, link: q_q, fep: cur_len_q - LW'(1)};
          state_d = S_DONE;
        end else begin
          cl_d = node_cnt_q[NW-1:0];
          node_cnt_d = node_cnt_q + 1'b1;
          n_waddr = node_cnt_q[NW-1:0];
          n_wdata = '{len: lenp_q + 1'b1, link: nd.link, fep: nd.fep};
          qword_d = nd;
          k_d = '0;
          state_d = A_COPY;
        end
      end
      A_COPY: begin
        e_raddr = {q_q, k_q[SW-1:0]};
        e_waddr = {cl_q, k_q[SW-1:0] - 1'b1};
        e_wdata = e_rdata;
        e_we = (k_q != '0);
        k_d = k_q + 1'b1;
        if (k_q == (SW+1)'(sab_pkg::ALPHABET)) begin
          state_d = A_RDP;
        end
      end
      A_RDP: begin
        state_d = A_REDIR;
      end
      A_REDIR: begin
        e_wdata = cl_q;
        if (e_rdata == q_q) begin
          e_we = 1'b1;
          if (p_q == '0) begin
            state_d = A_FIXQ;
          end else begin
            p_d = nd.link;
            e_raddr = {nd.link, sym_q};
            n_raddr = nd.link;
          end
        end else begin
          state_d = A_FIXQ;
        end
      end
      A_FIXQ: begin
        n_we = 1'b1;
        n_waddr = q_q;
        n_wdata = '{len: qword_q.len, link: cl_q, fep: qword_q.fep};
        state_d = A_FIXCUR;
      end
      A_FIXCUR: begin
        n_we = 1'b1;
        state_d = S_DONE;
      end
      Q_EDGE: begin
        n_raddr = e_rdata;
        if (e_rdata == '0 || qlen_q > text_len_q) begin
          qfail_d = 1'b1;
          if (pend_q) begin
            qnode_d = '0;
            qlen_d = '0;
            qfail_d = 1'b0;
            state_d = S_DONE;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          qnode_d = e_rdata;
          state_d = pend_q ? Q_POS : S_IDLE;
        end
      end
      Q_POS: begin
        res_found_d = 1'b1;
        res_pos_d = pos_full[sab_pkg::POS_W-1:0];
        qnode_d = '0;
        qlen_d = '0;
        qfail_d = 1'b0;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          status_d = res_st_q;
          found_d = res_found_q;
          pos_d = res_pos_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q <= '0;
      node_cnt_q <= (NW+1)'(1);
      last_q <= '0;
      qnode_q <= '0;
      text_len_q <= '0;
      qlen_q <= '0;
      qfail_q <= 1'b0;
      out_valid_q <= 1'b0;
      n_root_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      node_cnt_q <= node_cnt_d;
      last_q <= last_d;
      qnode_q <= qnode_d;
      text_len_q <= text_len_d;
      qlen_q <= qlen_d;
      qfail_q <= qfail_d;
      out_valid_q <= out_valid_d;
      n_root_q <= (n_raddr == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
    pend_q <= pend_d;
    p_q <= p_d;
    q_q <= q_d;
    cl_q <= cl_d;
    cur_q <= cur_d;
    cur_len_q <= cur_len_d;
    lenp_q <= lenp_d;
    qword_q <= qword_d;
    k_q <= k_d;
    res_st_q <= res_st_d;
    res_found_q <= res_found_d;
    res_pos_q <= res_pos_d;
    status_q <= status_d;
    found_q <= found_d;
    pos_q <= pos_d;
  end

  `SAB_ASSERT_NOW(a_busy_stalls, state_q != S_IDLE, in_stall_o)
  `SAB_ASSERT_NOW(a_node_cap, 1'b1, node_cnt_q <= (NW+1)'(sab_pkg::NODE_CAP))
  `SAB_ASSERT_NOW(a_text_cap, 1'b1, text_len_q <= LW'(sab_pkg::MAX_TEXT))
  `SAB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
endmodule
`default_nettype wire

@@ hw/rtl/sab_ram.sv @@
// single port write, single port read ram with registered read data
`default_nettype none
module sab_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// testbench for the suffix automaton block: directed and random appends and queries checked beat by beat
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    bit       mode;
    bit [7:0] sym;
    bit       pend;
    bit       drain;
  } beat_t;

  typedef struct {
    bit [1:0]                status;
    bit                      found;
    bit [sab_pkg::POS_W-1:0] pos;
  } answer_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic                      mode_i = 1'b0;
  logic [7:0]                symbol_i = 8'd0;
  logic                      pattern_end_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [1:0]                status_o;
  logic                      found_o;
  logic [sab_pkg::POS_W-1:0] position_o;

  suffix_automaton_build_and_match dut (.*);

  always #2 clk_i = ~clk_i;

  beat_t   pending_beats[$];
  answer_t expected_answers[$];
  int      errors = 0;
  int      beats_in = 0;
  int      beats_out = 0;
  bit      draining = 1'b0;

  // automaton shadow
  logic [sab_pkg::NODE_W-1:0] sa_edge[sab_pkg::NODE_CAP*sab_pkg::ALPHABET];
  int  sa_len[sab_pkg::NODE_CAP];
  int  sa_link[sab_pkg::NODE_CAP];
  int  sa_fep[sab_pkg::NODE_CAP];
  int  sa_count = 1;
  int  sa_last = 0;
  int  txt_len = 0;
  int  q_node = 0;
  int  q_len = 0;
  bit  q_fail = 1'b0;

  initial begin
    foreach (sa_edge[k]) sa_edge[k] = '0;
    foreach (sa_len[k]) begin
      sa_len[k] = 0;
      sa_link[k] = 0;
      sa_fep[k] = 0;
    end
  end

  function automatic int eidx(int node, int c);
    return node * sab_pkg::ALPHABET + c;
  endfunction

  function automatic void extend_text(int c);
    int cur, p, q, cl;
    bit have_p;
    cur = sa_count++;
    p = sa_last;
    have_p = 1'b1;
    sa_len[cur] = sa_len[sa_last] + 1;
    sa_fep[cur] = sa_len[cur] - 1;
    sa_link[cur] = 0;
    sa_last = cur;
    while (have_p && sa_edge[eidx(p, c)] == 0) begin
      sa_edge[eidx(p, c)] = cur;
      if (p == 0) have_p = 1'b0;
      else p = sa_link[p];
    end
    if (!have_p) return;
    q = sa_edge[eidx(p, c)];
    if (sa_len[q] == sa_len[p] + 1) begin
      sa_link[cur] = q;
    end else begin
      cl = sa_count++;
      for (int a = 0; a < sab_pkg::ALPHABET; a++) sa_edge[eidx(cl, a)] = sa_edge[eidx(q, a)];
      sa_len[cl] = sa_len[p] + 1;
      sa_fep[cl] = sa_fep[q];
      sa_link[cl] = sa_link[q];
      while (have_p && sa_edge[eidx(p, c)] == q) begin
        sa_edge[eidx(p, c)] = cl;
        if (p == 0) have_p = 1'b0;
        else p = sa_link[p];
      end
      sa_link[q] = cl;
      sa_link[cur] = cl;
    end
  endfunction

  function automatic void predict_beat(beat_t b);
    answer_t a;
    int nxt;
    a = '{status: sab_pkg::ST_APPENDED, found: 1'b0, pos: '0};
    if (!b.mode) begin
      q_node = 0; q_len = 0; q_fail = 1'b0;
      if (txt_len >= sab_pkg::MAX_TEXT) begin
        a.status = sab_pkg::ST_FULL;
      end else begin
        extend_text(b.sym % sab_pkg::ALPHABET);
        txt_len++;
      end
      expected_answers.push_back(a);
      return;
    end
    if (q_len < 65535) q_len++;
    if (!q_fail) begin
      nxt = sa_edge[eidx(q_node, b.sym % sab_pkg::ALPHABET)];
      if (nxt == 0 || q_len > txt_len) q_fail = 1'b1;
      else q_node = nxt;
    end
    if (!b.pend) return;
    a.status = sab_pkg::ST_ANSWER;
    if (!q_fail) begin
      a.found = 1'b1;
      a.pos = sab_pkg::POS_W'(sa_fep[q_node] + 1 - q_len);
    end
    expected_answers.push_back(a);
    q_node = 0; q_len = 0; q_fail = 1'b0;
  endfunction

  function automatic bit quiet_stretch();
    return beats_in >= 300 && beats_in < 500;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_beat('{mode: mode_i, sym: symbol_i, pend: pattern_end_i, drain: 1'b0});
        beats_in++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_beats.size() > 0 && pending_beats[0].drain && !draining) begin
          draining = 1'b1;
        end
        if (draining && expected_answers.size() == 0 && !(in_valid_i && in_stall_o)) begin
          draining = 1'b0;
          pending_beats[0].drain = 1'b0;
        end
        if (pending_beats.size() > 0 && !draining
            && (quiet_stretch() || $urandom_range(0, 99) >= 31)) begin
          mode_i <= pending_beats[0].mode;
          symbol_i <= pending_beats[0].sym;
          pattern_end_i <= pending_beats[0].pend;
          in_valid_i <= 1'b1;
          void'(pending_beats.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off
  int  hold_cycles = 0;
  bit  held = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall_i <= 1'b1;
    end else if (!held && beats_in >= 800) begin
      held = 1'b1;
      hold_cycles = 400;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet_stretch() && $urandom_range(0, 99) < 31;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_out++;
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result beat status=%0d found=%0d position=%0d",
                 $time, status_o, found_o, position_o);
        errors++;
      end else begin
        e = expected_answers.pop_front();
        if (status_o !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status_o);
          errors++;
        end
        if (found_o !== e.found) begin
          $display("%0t: found expected %0d actual %0d", $time, e.found, found_o);
          errors++;
        end
        if (position_o !== e.pos) begin
          $display("%0t: position expected %0d actual %0d", $time, e.pos, position_o);
          errors++;
        end
      end
    end
  end

  byte unsigned gen_text[$];

  task automatic add_beat(bit m, bit [7:0] s, bit p, bit d = 1'b0);
    pending_beats.push_back('{mode: m, sym: s, pend: p, drain: d});
    if (!m && gen_text.size() < sab_pkg::MAX_TEXT) gen_text.push_back(s);
  endtask

  task automatic add_pattern(string pat);
    for (int k = 0; k < pat.len(); k++) add_beat(1'b1, pat[k], k == pat.len() - 1);
  endtask

  task automatic add_random_query();
    int plen, start;
    bit cut;
    cut = $urandom_range(0, 9) == 0;
    if (gen_text.size() > 0 && $urandom_range(0, 9) < 8) begin
      plen = $urandom_range(1, (gen_text.size() < 12) ? gen_text.size() : 12);
      start = $urandom_range(0, gen_text.size() - plen);
      for (int k = 0; k < plen; k++)
        add_beat(1'b1, gen_text[start + k], !cut && k == plen - 1);
    end else begin
      plen = $urandom_range(1, 6);
      for (int k = 0; k < plen; k++)
        add_beat(1'b1, $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(97, 100)),
                 !cut && k == plen - 1);
    end
  endtask

  initial begin
    bit drain_added;
    drain_added = 1'b0;
    // directed
    add_pattern("a");
    add_beat(1'b0, 8'h00, 1'b0);
    add_beat(1'b0, 8'hff, 1'b1);
    add_pattern("a");
    add_beat(1'b1, 8'hff, 1'b1);
    add_beat(1'b1, 8'h00, 1'b1);
    add_beat(1'b0, "a", 1'b0);
    add_beat(1'b0, "b", 1'b0);
    add_beat(1'b0, "a", 1'b0);
    add_beat(1'b0, "b", 1'b0);
    add_beat(1'b0, "b", 1'b0);
    add_pattern("ab");
    add_pattern("bb");
    add_pattern("abb");
    add_pattern("zz");
    add_pattern("aaaaaaaa");
    add_beat(1'b1, "a", 1'b0);
    add_beat(1'b1, "b", 1'b0);
    add_beat(1'b0, "a", 1'b0);
    add_pattern("ba");

    // random
    while (pending_beats.size() < 1500 || gen_text.size() < sab_pkg::MAX_TEXT) begin
      if (!drain_added && pending_beats.size() >= 700) begin
        drain_added = 1'b1;
        add_beat(1'b0, 8'($urandom_range(97, 100)), 1'b0, 1'b1);
      end else if ($urandom_range(0, 99) < 92) begin
        add_beat(1'b0, $urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(97, 100)),
                 1'($urandom_range(0, 1)));
      end else begin
        add_random_query();
      end
    end
    repeat (12) add_beat(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    repeat (15) add_random_query();
    add_pattern("a");

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_beats.size() == 0 && !in_valid_i && expected_answers.size() == 0);
    repeat (400) @(posedge clk_i);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #80000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/sab_pkg.sv
hw/rtl/sab_ram.sv
hw/rtl/suffix_automaton_build_and_match.sv
dv/testbench.sv
